// ===== src/tcce_pkg.sv =====
// Shared types and constants for the text console cursor engine.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package tcce_pkg;

  // Screen and tab geometry limits
  localparam int MAX_COLUMNS = 512;
  localparam int MAX_ROWS    = 256;
  // Tab stop must stay a power of two: the stop offset is taken from low cursor bits
  localparam int TAB_STOP    = 8;

  // Cursor widths hold the full count so a cursor one past the edge is visible
  localparam int COL_W  = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int TAB_W  = $clog2(TAB_STOP);
  localparam int LEFT_W = $clog2(TAB_STOP + 1);

  // Fixed field widths of the channels
  localparam int CODE_W     = 8;
  localparam int COLOR_W    = 32;
  localparam int CELL_COL_W = 9;
  localparam int CELL_ROW_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_COLS_W = 10;
  localparam int CFG_ROWS_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b1;
  localparam logic [COL_W-1:0] RESET_COLUMNS = COL_W'(80);
  localparam logic [ROW_W-1:0] RESET_ROWS    = ROW_W'(25);

  // Character codes
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CODE_W-1:0] CODE_TAB       = 8'd9;
  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CODE_W-1:0] CODE_SPACE     = 8'd32;

  // Result kinds
  localparam logic KIND_CELL   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0]  char_code;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
  } in_item_t;

  typedef struct packed {
    logic                  result_kind;
    logic [CELL_COL_W-1:0] cell_column;
    logic [CELL_ROW_W-1:0] cell_row;
    logic [CODE_W-1:0]     glyph_code;
    logic [COLOR_W-1:0]    cell_fg;
    logic [COLOR_W-1:0]    cell_bg;
    logic                  last_result;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // latch request, saturate cursor
    logic step;     // newline update, or one cell write and cursor advance
    logic scroll;   // emit one scroll result
  } tcce_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_newline;
    logic scroll_due;
    logic left_one;
    logic left_zero;
    logic out_free;
  } tcce_stat_t;

endpackage

// ===== src/tcce_in_if.sv =====
// Character request channel: valid/ready handshake with one input item.
// Depends on tcce_pkg.
`timescale 1ns / 1ps

interface tcce_in_if import tcce_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/tcce_out_if.sv =====
// Result channel: valid/ready handshake carrying cell writes and scrolls.
// Depends on tcce_pkg.
`timescale 1ns / 1ps

interface tcce_out_if import tcce_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/text_console_cursor_engine_core.sv =====
// Top level of the text console cursor engine: sequencer plus datapath.
// Depends on tcce_pkg, tcce_in_if, tcce_out_if, tcce_ctrl, tcce_dpath.
//
//   channel   dir  handshake        payload
//   char_i    in   valid/ready      char_code, fg_color, bg_color
//   cell_o    out  valid/ready      cell write or scroll, last_result marks the end
//   cfg_*     in   cfg_we_i         index 0 columns_in_use, 1 rows_in_use
//
// A glyph is accepted, then writes its cell, then scrolls if it passes the bottom.
// A backspace is accepted, then writes its cell. A newline is accepted, then moves
// the cursor, then scrolls if it passes the bottom. A tab is accepted, then writes one space per step plus its scrolls;
// the sequencer emits one result a cycle while the output is not stalled.
// Reset puts the cursor at column 0, row 0 and the screen at 80 by 25; no clearing pass.
// A stalled output holds the sequencer in place; the next character is taken
// once the current one has placed its last result in the output register.
`timescale 1ns / 1ps

module text_console_cursor_engine_core import tcce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tcce_in_if.sink               char_i,
  tcce_out_if.source            cell_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  tcce_cmd_t  cmd;
  tcce_stat_t stat;
  logic       in_ready;

  // Sequencer
  tcce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (char_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Cursor and result datapath
  tcce_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (char_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (cell_o.valid),
    .out_ready_i (cell_o.ready),
    .out_data_o  (cell_o.data)
  );

  assign char_i.ready = in_ready;

endmodule

// ===== src/tcce_ctrl.sv =====
// Sequencer for the cursor engine: accept, per-cell step, scroll.
// Depends on tcce_pkg; drives tcce_dpath through tcce_cmd_t.
`timescale 1ns / 1ps

module tcce_ctrl import tcce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  tcce_stat_t stat_i,
  output tcce_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.is_newline) begin
          // newline writes nothing, so it never waits on the output
          cmd_o.step = 1'b1;
          state_d    = stat_i.scroll_due ? ST_SCROLL : ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.step = 1'b1;
          if (stat_i.scroll_due) begin
            state_d = ST_SCROLL;
          end else if (stat_i.left_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SCROLL: begin
        if (stat_i.out_free) begin
          cmd_o.scroll = 1'b1;
          state_d      = stat_i.left_zero ? ST_IDLE : ST_EXEC;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Checks
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.step, cmd_o.scroll}))
    else $error("more than one datapath command at once");

  a_write_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.step && !stat_i.is_newline) || cmd_o.scroll |-> stat_i.out_free)
    else $error("result loaded into an occupied output register");

  a_scroll_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) && cmd_o.step && stat_i.scroll_due |=> (state_q == ST_SCROLL))
    else $error("due scroll skipped");

  a_idle_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_EXEC) && !in_ready_o)
    else $error("second request taken while one is in progress");

endmodule

// ===== src/tcce_dpath.sv =====
// Datapath for the cursor engine: config, cursor, request and output registers.
// Depends on tcce_pkg; commanded by tcce_ctrl.
`timescale 1ns / 1ps

module tcce_dpath import tcce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  in_item_t              in_data_i,
  input  tcce_cmd_t             cmd_i,
  output tcce_stat_t            stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o
);

  logic [COL_W-1:0]   cols_q, cols_d;
  logic [ROW_W-1:0]   rows_q, rows_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [LEFT_W-1:0]  left_q, left_d;
  logic [CODE_W-1:0]  code_q;
  logic [COLOR_W-1:0] fg_q, bg_q;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic [CFG_COLS_W-1:0] cfg_cols_raw;
  logic [CFG_ROWS_W-1:0] cfg_rows_raw;
  logic [COL_W-1:0]      sat_col, col_inc, bs_col, cell_col;
  logic [ROW_W-1:0]      sat_row, row_inc, row_after, bs_row, cell_row;
  logic                  is_nl, is_bs, is_tab, wrap, scroll_w, scroll_n, scroll_due, out_free;

  // Config writes, clamped to the legal screen range on the way in
  assign cfg_cols_raw = cfg_data_i[CFG_COLS_W-1:0];
  assign cfg_rows_raw = cfg_data_i[CFG_ROWS_W-1:0];

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COLUMNS: begin
          if (cfg_cols_raw == '0) begin
            cols_d = COL_W'(1);
          end else if (cfg_cols_raw > MAX_COLUMNS) begin
            cols_d = COL_W'(MAX_COLUMNS);
          end else begin
            cols_d = COL_W'(cfg_cols_raw);
          end
        end
        CFG_ROWS: begin
          if (cfg_rows_raw == '0) begin
            rows_d = ROW_W'(1);
          end else if (cfg_rows_raw > MAX_ROWS) begin
            rows_d = ROW_W'(MAX_ROWS);
          end else begin
            rows_d = ROW_W'(cfg_rows_raw);
          end
        end
        default: ;
      endcase
    end
  end

  // Cursor saturation at request time (screen may have shrunk)
  assign sat_col = (col_q >= cols_q) ? cols_q - 1'b1 : col_q;
  assign sat_row = (row_q >= rows_q) ? rows_q - 1'b1 : row_q;

  // Decode of the held character
  assign is_nl  = (code_q == CODE_NEWLINE);
  assign is_bs  = (code_q == CODE_BACKSPACE);
  assign is_tab = (code_q == CODE_TAB);

  // Advance after a cell write, with wrap and scroll check
  assign col_inc   = col_q + 1'b1;
  assign row_inc   = row_q + 1'b1;
  assign wrap      = (col_inc >= cols_q);
  assign row_after = wrap ? row_inc : row_q;
  assign scroll_w  = wrap && (row_after >= rows_q);
  assign scroll_n  = (row_inc >= rows_q);

  // Backspace steps back, wrapping to the previous row and then to the last row
  assign bs_col = (col_q == '0) ? cols_q - 1'b1 : col_q - 1'b1;
  assign bs_row = (col_q != '0) ? row_q :
                  (row_q == '0) ? rows_q - 1'b1 : row_q - 1'b1;

  assign scroll_due = is_nl ? scroll_n : (is_bs ? 1'b0 : scroll_w);
  assign cell_col   = is_bs ? bs_col : col_q;
  assign cell_row   = is_bs ? bs_row : row_q;
  assign out_free   = !out_valid_q || out_ready_i;

  // Cursor, remaining-count and output register updates
  always_comb begin
    col_d       = col_q;
    row_d       = row_q;
    left_d      = left_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.accept) begin
      col_d = sat_col;
      row_d = sat_row;
      if (in_data_i.char_code == CODE_TAB) begin
        left_d = LEFT_W'(TAB_STOP) - LEFT_W'(sat_col[TAB_W-1:0]);
      end else if (in_data_i.char_code == CODE_NEWLINE) begin
        left_d = '0;
      end else begin
        left_d = LEFT_W'(1);
      end
    end else if (cmd_i.step) begin
      if (is_nl) begin
        col_d = '0;
        row_d = scroll_n ? rows_q - 1'b1 : row_inc;
      end else begin
        if (is_bs) begin
          col_d = bs_col;
          row_d = bs_row;
        end else begin
          col_d = wrap ? '0 : col_inc;
          row_d = scroll_w ? rows_q - 1'b1 : row_after;
        end
        left_d            = left_q - 1'b1;
        out_valid_d       = 1'b1;
        out_d.result_kind = KIND_CELL;
        out_d.cell_column = cell_col[CELL_COL_W-1:0];
        out_d.cell_row    = cell_row[CELL_ROW_W-1:0];
        out_d.glyph_code  = (is_tab || is_bs) ? CODE_SPACE : code_q;
        out_d.cell_fg     = fg_q;
        out_d.cell_bg     = bg_q;
        out_d.last_result = (left_q == LEFT_W'(1)) && !scroll_due;
      end
    end else if (cmd_i.scroll) begin
      out_valid_d       = 1'b1;
      out_d             = '0;
      out_d.result_kind = KIND_SCROLL;
      out_d.last_result = (left_q == '0);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q      <= RESET_COLUMNS;
      rows_q      <= RESET_ROWS;
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cols_q      <= cols_d;
      rows_q      <= rows_d;
      col_q       <= col_d;
      row_q       <= row_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (cmd_i.accept) begin
      code_q <= in_data_i.char_code;
      fg_q   <= in_data_i.fg_color;
      bg_q   <= in_data_i.bg_color;
    end
  end

  assign stat_o.is_newline = is_nl;
  assign stat_o.scroll_due = scroll_due;
  assign stat_o.left_one   = (left_q == LEFT_W'(1));
  assign stat_o.left_zero  = (left_q == '0);
  assign stat_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_col_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> col_q < $past(cols_q))
    else $error("cursor column left the screen after a step");

  a_row_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> row_q < $past(rows_q))
    else $error("cursor row left the screen after a step");

  a_scroll_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.result_kind == KIND_SCROLL) |->
      (out_q.cell_column == '0) && (out_q.cell_row == '0) && (out_q.glyph_code == '0))
    else $error("scroll result carries cell data");

endmodule

// ===== bench/text_console_cursor_engine_core_test.sv =====
// Self-checking bench for text_console_cursor_engine_core: a directed table, then random
// console text over several screen sizes with random request gaps and output stalls.
// Depends on tcce_pkg, tcce_in_if, tcce_out_if and the engine RTL.
`timescale 1ns / 1ps

module text_console_cursor_engine_core_test;
  import tcce_pkg::*;

  localparam int MAX_BURST     = 16;  // results one character may cause
  localparam int SETTLE_CYCLES = 8;   // a newline without result may still be in flight
  localparam int DIR_ROWS      = 28;
  localparam int PHASES        = 9;
  localparam int PHASE_CHARS   = 32;

  typedef enum logic [1:0] {ROW_CHAR, ROW_COLS, ROW_ROWS} row_op_e;

  // For register rows the value rides in fg.
  typedef struct {
    row_op_e     op;
    logic [7:0]  code;
    logic [31:0] fg;
    logic [31:0] bg;
    bit          typed;
    logic        tkind;
    int          tcol;
    int          trow;
    logic [7:0]  tglyph;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tcce_in_if  char_if ();
  tcce_out_if cell_if ();

  text_console_cursor_engine_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_i     (char_if),
    .cell_o     (cell_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the engine: cursor and screen registers
  int                    cur_col;
  int                    cur_row;
  logic [CFG_COLS_W-1:0] scr_cols;
  logic [CFG_ROWS_W-1:0] scr_rows;
  out_item_t             char_cells_q[$];  // results of the character just taken
  out_item_t             cell_exp_q[$];    // results still owed by the engine

  int        err_count;
  int        send_gap_pct;
  int        stall_pct;
  bit        typed_on;
  out_item_t typed_res;

  stim_row_t dir_tab [DIR_ROWS] = '{
    // after reset: backspace wraps to the last column of the last row
    '{ROW_CHAR, CODE_BACKSPACE, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 1'b1, KIND_CELL, 79, 24,
      CODE_SPACE},
    '{ROW_CHAR, 8'h41, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_CHAR, CODE_NEWLINE, 32'h1357_9BDF, 32'h2468_ACE0, 1'b1, KIND_SCROLL, 0, 0, 8'h00},
    '{ROW_CHAR, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, KIND_CELL, 0, 24, 8'h00},
    '{ROW_CHAR, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, KIND_CELL, 1, 24, 8'hFF},
    '{ROW_CHAR, CODE_BACKSPACE, 32'h0000_0001, 32'h8000_0000, 1'b1, KIND_CELL, 1, 24,
      CODE_SPACE},
    '{ROW_CHAR, CODE_TAB, 32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_CHAR, CODE_TAB, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_CHAR, CODE_NEWLINE, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_SCROLL, 0, 0, 8'h00},
    // 8 by 1 screen: cursor row is pulled back onto the screen
    '{ROW_COLS, 8'h00, 32'd8, 32'h0, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_ROWS, 8'h00, 32'd1, 32'h0, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_CHAR, 8'h78, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1, KIND_CELL, 0, 0, 8'h78},
    '{ROW_CHAR, CODE_TAB, 32'h0F1E_2D3C, 32'h4B5A_6978, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_CHAR, CODE_BACKSPACE, 32'h7777_7777, 32'h3333_3333, 1'b1, KIND_CELL, 7, 0,
      CODE_SPACE},
    '{ROW_CHAR, CODE_NEWLINE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, KIND_SCROLL, 0, 0, 8'h00},
    // zero counts act as one: every tab space wraps and scrolls
    '{ROW_COLS, 8'h00, 32'd0, 32'h0, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_ROWS, 8'h00, 32'd0, 32'h0, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_CHAR, CODE_TAB, 32'h0101_0101, 32'hFEFE_FEFE, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_CHAR, CODE_BACKSPACE, 32'h6666_9999, 32'h9999_6666, 1'b1, KIND_CELL, 0, 0,
      CODE_SPACE},
    // counts past the maximum clip to 512 by 256
    '{ROW_COLS, 8'h00, 32'd1023, 32'h0, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_ROWS, 8'h00, 32'd511, 32'h0, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_CHAR, CODE_BACKSPACE, 32'hC3C3_3C3C, 32'h3C3C_C3C3, 1'b1, KIND_CELL, 511, 255,
      CODE_SPACE},
    '{ROW_CHAR, 8'h71, 32'h2222_4444, 32'h8888_1111, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_CHAR, CODE_TAB, 32'hBEEF_0000, 32'h0000_BEEF, 1'b0, KIND_CELL, 0, 0, 8'h00},
    // back to 80 by 25 with the cursor below the last row
    '{ROW_COLS, 8'h00, 32'd80, 32'h0, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_ROWS, 8'h00, 32'd25, 32'h0, 1'b0, KIND_CELL, 0, 0, 8'h00},
    '{ROW_CHAR, 8'h42, 32'h0BAD_F00D, 32'hF00D_0BAD, 1'b1, KIND_CELL, 8, 24, 8'h42},
    '{ROW_CHAR, CODE_NEWLINE, 32'h1111_1111, 32'h2222_2222, 1'b1, KIND_SCROLL, 0, 0, 8'h00}
  };

  // Predictor
  function automatic void add_result(logic kind, int col, int row, logic [7:0] glyph,
                                     logic [31:0] fg, logic [31:0] bg);
    out_item_t r;
    if (char_cells_q.size() >= MAX_BURST) return;
    r.result_kind = kind;
    r.cell_column = CELL_COL_W'(col);
    r.cell_row    = CELL_ROW_W'(row);
    r.glyph_code  = glyph;
    r.cell_fg     = fg;
    r.cell_bg     = bg;
    r.last_result = 1'b0;
    char_cells_q.push_back(r);
  endfunction

  // Wrap at the right edge, scroll past the bottom
  function automatic void wrap_cursor(int cols, int rows);
    if (cur_col >= cols) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= rows) begin
      add_result(KIND_SCROLL, 0, 0, 8'h00, 32'h0, 32'h0);
      cur_row = rows - 1;
    end
  endfunction

  function automatic void predict_cells(in_item_t it);
    int cols;
    int rows;
    int left;
    char_cells_q.delete();
    cols = (scr_cols == 0) ? 1 : ((scr_cols > MAX_COLUMNS) ? MAX_COLUMNS : int'(scr_cols));
    rows = (scr_rows == 0) ? 1 : ((scr_rows > MAX_ROWS) ? MAX_ROWS : int'(scr_rows));
    // registers may have shrunk under the cursor
    if (cur_col >= cols) cur_col = cols - 1;
    if (cur_row >= rows) cur_row = rows - 1;
    case (it.char_code)
      CODE_NEWLINE: begin
        cur_col = 0;
        cur_row++;
        wrap_cursor(cols, rows);
      end
      CODE_BACKSPACE: begin
        if (cur_col == 0) begin
          cur_col = cols - 1;
          cur_row = (cur_row == 0) ? rows - 1 : cur_row - 1;
        end else begin
          cur_col--;
        end
        add_result(KIND_CELL, cur_col, cur_row, CODE_SPACE, it.fg_color, it.bg_color);
        wrap_cursor(cols, rows);
      end
      CODE_TAB: begin
        left = (cur_col / TAB_STOP + 1) * TAB_STOP - cur_col;
        while (left > 0) begin
          left--;
          add_result(KIND_CELL, cur_col, cur_row, CODE_SPACE, it.fg_color, it.bg_color);
          cur_col++;
          wrap_cursor(cols, rows);
        end
      end
      default: begin
        add_result(KIND_CELL, cur_col, cur_row, it.char_code, it.fg_color, it.bg_color);
        cur_col++;
        wrap_cursor(cols, rows);
      end
    endcase
    if (char_cells_q.size() > 0) char_cells_q[char_cells_q.size() - 1].last_result = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endfunction

  // Character requests taken: queue what they should produce
  always @(posedge clk_i) begin
    if (rst_ni && char_if.valid && char_if.ready) begin
      predict_cells(char_if.data);
      if (typed_on) cell_exp_q.push_back(typed_res);
      else foreach (char_cells_q[k]) cell_exp_q.push_back(char_cells_q[k]);
    end
  end

  // Results taken: compare with the oldest one owed
  always @(posedge clk_i) begin : cell_check
    out_item_t want;
    out_item_t got;
    if (rst_ni && cell_if.valid && cell_if.ready) begin
      got = cell_if.data;
      if (cell_exp_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        err_count++;
      end else begin
        want = cell_exp_q.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
        check_field("cell_column", 32'(want.cell_column), 32'(got.cell_column));
        check_field("cell_row",    32'(want.cell_row),    32'(got.cell_row));
        check_field("glyph_code",  32'(want.glyph_code),  32'(got.glyph_code));
        check_field("cell_fg",     want.cell_fg,          got.cell_fg);
        check_field("cell_bg",     want.cell_bg,          got.cell_bg);
        check_field("last_result", 32'(want.last_result), 32'(got.last_result));
      end
    end
  end

  // Output stalls
  always @(negedge clk_i) begin
    cell_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_char(in_item_t it);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      char_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    char_if.valid <= 1'b1;
    char_if.data  <= it;
    @(posedge clk_i);
    while (!char_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stop sending until every owed result is out and the engine has gone quiet
  task automatic wait_drained();
    char_if.valid <= 1'b0;
    while (cell_exp_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == CFG_COLUMNS) scr_cols = val;
    else scr_rows = val[CFG_ROWS_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    in_item_t it;
    int       cols_set [PHASES];
    int       rows_set [PHASES];
    int       pick;
    char_if.valid = 1'b0;
    char_if.data  = '0;
    cell_if.ready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_COLUMNS;
    cfg_data_i    = '0;
    rst_ni        = 1'b0;
    send_gap_pct  = 0;
    stall_pct     = 0;
    typed_on      = 1'b0;
    typed_res     = '0;
    err_count     = 0;
    cur_col       = 0;
    cur_row       = 0;
    scr_cols      = CFG_COLS_W'(80);
    scr_rows      = CFG_ROWS_W'(25);
    cols_set = '{80, 8, 0, 1023, 512, 9, 13, 0, 0};
    rows_set = '{25, 1, 0, 511, 256, 3, 2, 0, 0};
    cols_set[7] = $urandom_range(0, 1023);
    rows_set[7] = $urandom_range(0, 511);
    cols_set[8] = $urandom_range(8, 40);
    rows_set[8] = $urandom_range(1, 6);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (dir_tab[i]) begin
      case (dir_tab[i].op)
        ROW_COLS: set_reg(CFG_COLUMNS, dir_tab[i].fg[CFG_DATA_W-1:0]);
        ROW_ROWS: set_reg(CFG_ROWS, dir_tab[i].fg[CFG_DATA_W-1:0]);
        default: begin
          typed_on              = dir_tab[i].typed;
          typed_res.result_kind = dir_tab[i].tkind;
          typed_res.cell_column = CELL_COL_W'(dir_tab[i].tcol);
          typed_res.cell_row    = CELL_ROW_W'(dir_tab[i].trow);
          typed_res.glyph_code  = dir_tab[i].tglyph;
          typed_res.cell_fg     = (dir_tab[i].tkind == KIND_CELL) ? dir_tab[i].fg : 32'h0;
          typed_res.cell_bg     = (dir_tab[i].tkind == KIND_CELL) ? dir_tab[i].bg : 32'h0;
          typed_res.last_result = 1'b1;
          it.char_code = dir_tab[i].code;
          it.fg_color  = dir_tab[i].fg;
          it.bg_color  = dir_tab[i].bg;
          send_char(it);
          typed_on = 1'b0;
        end
      endcase
    end

    // Random text, one screen size and idling mix per phase
    for (int p = 0; p < PHASES; p++) begin
      set_reg(CFG_COLUMNS, CFG_DATA_W'(cols_set[p]));
      set_reg(CFG_ROWS, CFG_DATA_W'(rows_set[p]));
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 54; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 54; end
        default: begin send_gap_pct = 21; stall_pct = 21; end
      endcase
      for (int k = 0; k < PHASE_CHARS; k++) begin
        // hold off mid-phase until the engine has caught up
        if (p == 3 && k == PHASE_CHARS / 2) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 14) it.char_code = CODE_NEWLINE;
        else if (pick < 28) it.char_code = CODE_BACKSPACE;
        else if (pick < 42) it.char_code = CODE_TAB;
        else it.char_code = 8'($urandom_range(0, 255));
        it.fg_color = $urandom;
        it.bg_color = $urandom;
        send_char(it);
      end
    end

    wait_drained();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
